@@ design/ges_pkg.sv @@
// ----------------------------------------------------------------------------
// Gaussian elimination solver package
// Datapath operation codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ges_pkg;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD_PIV,
      OP_DIV_ELIM,
      OP_DIV_BACK,
      OP_STORE_RATIO,
      OP_STORE_X,
      OP_ZERO_X,
      OP_LOAD_A,
      OP_MUL,
      OP_QMUL,
      OP_ACC,
      OP_CLR_SUM
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      ram_we;
      logic      wr_load;
      logic      mul_x;
   } dp_cmd_type;

   typedef struct packed {
      logic              piv_zero;
      logic              div_done;
      logic [DATA_W-1:0] x_value;
   } dp_status_type;

endpackage

@@ design/ges_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ges_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 72
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/ges_datapath.sv @@
// ----------------------------------------------------------------------------
// Gaussian elimination solver datapath
// Matrix memory, Q16.16 multiplier with truncation and saturation, the
// back-substitution accumulator, the solution registers and a radix-2
// restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ges_datapath import ges_pkg::*; #(
   parameter int MAX_EQUATIONS = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  dp_cmd_type                               cmd,
   input  logic [$clog2(MAX_EQUATIONS*(MAX_EQUATIONS+1))-1:0] raddr,
   input  logic [$clog2(MAX_EQUATIONS*(MAX_EQUATIONS+1))-1:0] waddr,
   input  logic [$clog2(MAX_EQUATIONS)-1:0]         x_idx,
   input  logic signed [DATA_W-1:0]                 element_value,
   output dp_status_type                            status
);

   localparam int DEPTH  = MAX_EQUATIONS * (MAX_EQUATIONS + 1);
   localparam int SUM_W  = DATA_W + $clog2(MAX_EQUATIONS) + 1;
   localparam int DIFF_W = SUM_W + 1;
   localparam int NUM_W  = DIFF_W + FRAC_W;
   localparam int CNT_W  = $clog2(NUM_W);

   logic signed [DATA_W-1:0] rdata;
   logic [DATA_W-1:0]        wdata;

   logic signed [DATA_W-1:0]   piv_ff, piv_in;
   logic signed [DATA_W-1:0]   ratio_ff, ratio_in;
   logic signed [DATA_W-1:0]   a_ff, a_in;
   logic signed [DATA_W-1:0]   b_ff, b_in;
   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic signed [DATA_W-1:0]   q_ff, q_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [DATA_W-1:0]   x_ff [MAX_EQUATIONS];
   logic signed [DATA_W-1:0]   x_wdata;
   logic                       x_we;

   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic signed [DIFF_W-1:0]   num_s;
   logic [DIFF_W-1:0]          num_mag;
   logic [DATA_W:0]            trial;
   logic                       trial_ge;
   logic signed [DATA_W-1:0]   div_result;
   logic signed [DATA_W-1:0]   mul_op;
   logic signed [2*DATA_W-1:0] prod_shr;
   logic signed [2*DATA_W-1:0] prod_trunc;
   logic signed [DATA_W-1:0]   qmul_sat;
   logic signed [DATA_W:0]     upd_diff;
   logic signed [DATA_W-1:0]   upd_sat;

   ges_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_matrix_ram (
      .clock (clock),
      .we    (cmd.ram_we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   // Product scaled back by 2^16 with truncation toward zero, then saturated.
   always_comb begin
      prod_shr   = prod_ff >>> FRAC_W;
      prod_trunc = prod_shr + ((prod_ff[2*DATA_W-1] && (prod_ff[FRAC_W-1:0] != '0)) ?
                               64'sd1 : 64'sd0);
      if (prod_trunc > 64'sd2147483647) begin
         qmul_sat = 32'sh7FFF_FFFF;
      end else if (prod_trunc < -64'sd2147483648) begin
         qmul_sat = 32'sh8000_0000;
      end else begin
         qmul_sat = prod_trunc[DATA_W-1:0];
      end
   end

   always_comb begin
      upd_diff = {b_ff[DATA_W-1], b_ff} - {q_ff[DATA_W-1], q_ff};
      if (upd_diff[DATA_W] != upd_diff[DATA_W-1]) begin
         upd_sat = upd_diff[DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         upd_sat = upd_diff[DATA_W-1:0];
      end
   end

   assign wdata = cmd.wr_load ? element_value : upd_sat;

   // Divider operands and quotient saturation.
   always_comb begin
      if (cmd.op == OP_DIV_BACK) begin
         num_s = DIFF_W'(rdata) - DIFF_W'(sum_ff);
      end else begin
         num_s = DIFF_W'(rdata);
      end
      num_mag  = num_s[DIFF_W-1] ? DIFF_W'(-num_s) : DIFF_W'(num_s);
      trial    = {rem_ff, quo_ff[NUM_W-1]};
      trial_ge = trial >= {1'b0, den_ff};
      if (neg_ff) begin
         if (quo_ff > NUM_W'(33'h0_8000_0000)) begin
            div_result = 32'sh8000_0000;
         end else begin
            div_result = -$signed(quo_ff[DATA_W-1:0]);
         end
      end else begin
         if (quo_ff > NUM_W'(33'h0_7FFF_FFFF)) begin
            div_result = 32'sh7FFF_FFFF;
         end else begin
            div_result = $signed(quo_ff[DATA_W-1:0]);
         end
      end
   end

   always_comb begin
      mul_op   = cmd.mul_x ? x_ff[x_idx] : ratio_ff;
      piv_in   = piv_ff;
      ratio_in = ratio_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      prod_in  = prod_ff;
      q_in     = q_ff;
      sum_in   = sum_ff;
      x_we     = 1'b0;
      x_wdata  = div_result;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      cnt_in   = cnt_ff;

      if (busy_ff) begin
         rem_in = trial_ge ? DATA_W'(trial - {1'b0, den_ff}) : trial[DATA_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], trial_ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end

      case (cmd.op)
         OP_LOAD_PIV: begin
            piv_in = rdata;
         end
         OP_DIV_ELIM, OP_DIV_BACK: begin
            rem_in  = '0;
            quo_in  = {num_mag, FRAC_W'(0)};
            den_in  = piv_ff[DATA_W-1] ? DATA_W'(-piv_ff) : DATA_W'(piv_ff);
            neg_in  = num_s[DIFF_W-1] ^ piv_ff[DATA_W-1];
            busy_in = 1'b1;
            done_in = 1'b0;
            cnt_in  = CNT_W'(NUM_W - 1);
         end
         OP_STORE_RATIO: begin
            ratio_in = div_result;
         end
         OP_STORE_X: begin
            x_we = 1'b1;
         end
         OP_ZERO_X: begin
            x_we    = 1'b1;
            x_wdata = '0;
         end
         OP_LOAD_A: begin
            a_in = rdata;
         end
         OP_MUL: begin
            prod_in = mul_op * a_ff;
            b_in    = rdata;
         end
         OP_QMUL: begin
            q_in = qmul_sat;
         end
         OP_ACC: begin
            sum_in = sum_ff + SUM_W'(q_ff);
         end
         OP_CLR_SUM: begin
            sum_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      piv_ff   <= piv_in;
      ratio_ff <= ratio_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      prod_ff  <= prod_in;
      q_ff     <= q_in;
      sum_ff   <= sum_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      if (x_we) begin
         x_ff[x_idx] <= x_wdata;
      end
   end

   assign status.piv_zero = (piv_ff == '0);
   assign status.div_done = done_ff;
   assign status.x_value  = x_ff[x_idx];

endmodule

@@ design/ges_ctrl.sv @@
// ----------------------------------------------------------------------------
// Gaussian elimination solver controller
// Holds the equation count, sequences matrix loading, forward elimination,
// back substitution and result delivery, and drives the datapath commands.
// ----------------------------------------------------------------------------
module ges_ctrl import ges_pkg::*; #(
   parameter int MAX_EQUATIONS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   csr_write_enable,
   input  logic [3:0]             csr_write_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_variable_index,
   output logic signed [DATA_W-1:0] rsp_solution_value,
   output logic                   rsp_singular,
   output logic                   rsp_last_result,
   output dp_cmd_type             cmd,
   output logic [$clog2(MAX_EQUATIONS*(MAX_EQUATIONS+1))-1:0] raddr,
   output logic [$clog2(MAX_EQUATIONS*(MAX_EQUATIONS+1))-1:0] waddr,
   output logic [$clog2(MAX_EQUATIONS)-1:0] x_idx,
   input  dp_status_type          status
);

   localparam int COLS   = MAX_EQUATIONS + 1;
   localparam int ADDR_W = $clog2(MAX_EQUATIONS * COLS);
   localparam int CNT_W  = $clog2(MAX_EQUATIONS + 1);
   localparam int XI_W   = $clog2(MAX_EQUATIONS);

   typedef enum logic [4:0] {
      S_LOAD,
      S_E_PRD, S_E_PLD, S_E_PCHK,
      S_E_RRD, S_E_RDIV, S_E_RWAIT,
      S_E_K0, S_E_K1, S_E_K2, S_E_K3, S_E_K4,
      S_B_START,
      S_B_J0, S_B_J1, S_B_J2, S_B_J3, S_B_J4,
      S_B_PRD, S_B_PLD, S_B_DIV, S_B_WAIT,
      S_O_SET, S_O_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic [3:0]       count_ff, count_in;
   logic [CNT_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic             sing_ff, sing_in;
   logic             valid_ff, valid_in;
   logic [2:0]       index_ff, index_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic             rsing_ff, rsing_in;
   logic             last_ff, last_in;
   logic [CNT_W-1:0] n;
   logic [CNT_W-1:0] i_next, j_next;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [CNT_W-1:0] r,
                                                 input logic [CNT_W-1:0] c);
      addr_of = ADDR_W'(r * COLS + c);
   endfunction

   always_comb begin
      if (count_ff == '0) begin
         n = CNT_W'(1);
      end else if (32'(count_ff) > MAX_EQUATIONS) begin
         n = CNT_W'(MAX_EQUATIONS);
      end else begin
         n = CNT_W'(count_ff);
      end
   end

   assign i_next = CNT_W'(i_ff + 1'b1);
   assign j_next = CNT_W'(j_ff + 1'b1);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      sing_in  = sing_ff;
      valid_in = valid_ff;
      index_in = index_ff;
      value_in = value_ff;
      rsing_in = rsing_ff;
      last_in  = last_ff;
      cmd      = '{op: OP_NONE, ram_we: 1'b0, wr_load: 1'b0, mul_x: 1'b0};
      raddr    = addr_of(i_ff, i_ff);
      waddr    = addr_of(row_ff, col_ff);
      x_idx    = i_ff[XI_W-1:0];

      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.ram_we  = 1'b1;
               cmd.wr_load = 1'b1;
               if (col_ff == n) begin
                  col_in = '0;
                  if (CNT_W'(row_ff + 1'b1) == n) begin
                     row_in   = '0;
                     i_in     = '0;
                     sing_in  = 1'b0;
                     state_in = S_E_PRD;
                  end else begin
                     row_in = CNT_W'(row_ff + 1'b1);
                  end
               end else begin
                  col_in = CNT_W'(col_ff + 1'b1);
               end
            end
         end
         S_E_PRD: begin
            raddr    = addr_of(i_ff, i_ff);
            state_in = S_E_PLD;
         end
         S_E_PLD: begin
            cmd.op   = OP_LOAD_PIV;
            state_in = S_E_PCHK;
         end
         S_E_PCHK: begin
            // A zero pivot leaves the rows below untouched for this column.
            if (status.piv_zero || i_next == n) begin
               sing_in = sing_ff | status.piv_zero;
               if (i_next == n) begin
                  i_in     = CNT_W'(n - 1'b1);
                  state_in = S_B_START;
               end else begin
                  i_in     = i_next;
                  state_in = S_E_PRD;
               end
            end else begin
               j_in     = i_next;
               state_in = S_E_RRD;
            end
         end
         S_E_RRD: begin
            raddr    = addr_of(j_ff, i_ff);
            state_in = S_E_RDIV;
         end
         S_E_RDIV: begin
            cmd.op   = OP_DIV_ELIM;
            state_in = S_E_RWAIT;
         end
         S_E_RWAIT: begin
            if (status.div_done) begin
               cmd.op   = OP_STORE_RATIO;
               k_in     = '0;
               state_in = S_E_K0;
            end
         end
         S_E_K0: begin
            raddr    = addr_of(i_ff, k_ff);
            state_in = S_E_K1;
         end
         S_E_K1: begin
            raddr    = addr_of(j_ff, k_ff);
            cmd.op   = OP_LOAD_A;
            state_in = S_E_K2;
         end
         S_E_K2: begin
            cmd.op   = OP_MUL;
            state_in = S_E_K3;
         end
         S_E_K3: begin
            cmd.op   = OP_QMUL;
            state_in = S_E_K4;
         end
         S_E_K4: begin
            cmd.ram_we = 1'b1;
            waddr      = addr_of(j_ff, k_ff);
            if (k_ff == n) begin
               if (j_next == n) begin
                  if (i_next == n) begin
                     i_in     = CNT_W'(n - 1'b1);
                     state_in = S_B_START;
                  end else begin
                     i_in     = i_next;
                     state_in = S_E_PRD;
                  end
               end else begin
                  j_in     = j_next;
                  state_in = S_E_RRD;
               end
            end else begin
               k_in     = CNT_W'(k_ff + 1'b1);
               state_in = S_E_K0;
            end
         end
         S_B_START: begin
            cmd.op = OP_CLR_SUM;
            j_in   = i_next;
            if (i_next == n) begin
               state_in = S_B_PRD;
            end else begin
               state_in = S_B_J0;
            end
         end
         S_B_J0: begin
            raddr    = addr_of(i_ff, j_ff);
            state_in = S_B_J1;
         end
         S_B_J1: begin
            cmd.op   = OP_LOAD_A;
            state_in = S_B_J2;
         end
         S_B_J2: begin
            cmd.op    = OP_MUL;
            cmd.mul_x = 1'b1;
            x_idx     = j_ff[XI_W-1:0];
            state_in  = S_B_J3;
         end
         S_B_J3: begin
            cmd.op   = OP_QMUL;
            state_in = S_B_J4;
         end
         S_B_J4: begin
            cmd.op = OP_ACC;
            if (j_next == n) begin
               state_in = S_B_PRD;
            end else begin
               j_in     = j_next;
               state_in = S_B_J0;
            end
         end
         S_B_PRD: begin
            raddr    = addr_of(i_ff, i_ff);
            state_in = S_B_PLD;
         end
         S_B_PLD: begin
            cmd.op   = OP_LOAD_PIV;
            raddr    = addr_of(i_ff, n);
            state_in = S_B_DIV;
         end
         S_B_DIV: begin
            if (status.piv_zero) begin
               cmd.op  = OP_ZERO_X;
               sing_in = 1'b1;
               if (i_ff == '0) begin
                  state_in = S_O_SET;
               end else begin
                  i_in     = CNT_W'(i_ff - 1'b1);
                  state_in = S_B_START;
               end
            end else begin
               cmd.op   = OP_DIV_BACK;
               state_in = S_B_WAIT;
            end
         end
         S_B_WAIT: begin
            if (status.div_done) begin
               cmd.op = OP_STORE_X;
               if (i_ff == '0) begin
                  state_in = S_O_SET;
               end else begin
                  i_in     = CNT_W'(i_ff - 1'b1);
                  state_in = S_B_START;
               end
            end
         end
         S_O_SET: begin
            valid_in = 1'b1;
            index_in = 3'(i_ff);
            value_in = sing_ff ? '0 : status.x_value;
            rsing_in = sing_ff;
            last_in  = (i_next == n);
            state_in = S_O_WAIT;
         end
         S_O_WAIT: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               if (i_next == n) begin
                  state_in = S_LOAD;
               end else begin
                  i_in     = i_next;
                  state_in = S_O_SET;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // A count write drops any partly loaded system.
      if (csr_write_enable) begin
         count_in = csr_write_data;
         row_in   = '0;
         col_in   = '0;
         sing_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= 4'd8;
         row_ff   <= '0;
         col_ff   <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         sing_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         sing_ff  <= sing_in;
         valid_ff <= valid_in;
      end
      index_ff <= index_in;
      value_ff <= value_in;
      rsing_ff <= rsing_in;
      last_ff  <= last_in;
   end

   assign req_stall          = (state_ff != S_LOAD);
   assign rsp_valid          = valid_ff;
   assign rsp_variable_index = index_ff;
   assign rsp_solution_value = value_ff;
   assign rsp_singular       = rsing_ff;
   assign rsp_last_result    = last_ff;

endmodule

@@ design/gaussian_elimination_solver_top.sv @@
// ----------------------------------------------------------------------------
// Gaussian elimination solver
// Q16.16 linear system solver: forward elimination without pivoting, then
// back substitution, one result item per unknown.
// ----------------------------------------------------------------------------
// The augmented matrix arrives one element per item in row-major order, n rows
// of n+1 columns, at one item per cycle. After the last element the input
// stalls while the system is solved: each elimination row pair costs one
// division plus a multiply and subtract per column through the single matrix
// RAM read port, and each back-substitution row costs a multiply and
// accumulate per known unknown plus one division. A division produces one
// quotient bit per cycle, 16+SUM_W+1 bits where SUM_W grows with
// MAX_EQUATIONS. The n result items then follow one at a time, each held
// while rsp_stall is high, before loading resumes. A zero pivot marks every
// result of that system singular with a value of zero.
module gaussian_elimination_solver_top import ges_pkg::*; #(
   parameter int MAX_EQUATIONS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_element_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_variable_index,
   output logic signed [DATA_W-1:0] rsp_solution_value,
   output logic                     rsp_singular,
   output logic                     rsp_last_result,
   input  logic                     csr_write_enable,
   input  logic [3:0]               csr_write_data
);

   localparam int ADDR_W = $clog2(MAX_EQUATIONS * (MAX_EQUATIONS + 1));
   localparam int XI_W   = $clog2(MAX_EQUATIONS);

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [ADDR_W-1:0] raddr;
   logic [ADDR_W-1:0] waddr;
   logic [XI_W-1:0]   x_idx;

   ges_ctrl #(
      .MAX_EQUATIONS (MAX_EQUATIONS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_variable_index (rsp_variable_index),
      .rsp_solution_value (rsp_solution_value),
      .rsp_singular       (rsp_singular),
      .rsp_last_result    (rsp_last_result),
      .cmd                (cmd),
      .raddr              (raddr),
      .waddr              (waddr),
      .x_idx              (x_idx),
      .status             (status)
   );

   ges_datapath #(
      .MAX_EQUATIONS (MAX_EQUATIONS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .raddr         (raddr),
      .waddr         (waddr),
      .x_idx         (x_idx),
      .element_value (req_element_value),
      .status        (status)
   );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian elimination solver testbench
// Feeds augmented matrices through the element channel. A built-in Q16.16
// solver predicts the result items, and the result channel is checked
// against them. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top import ges_pkg::*; ();

   localparam int MAX_EQ = 8;

   typedef struct {
      logic [2:0]  index;
      int          value;
      logic        singular;
      logic        last;
   } solution_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_element_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [2:0]               rsp_variable_index;
   logic signed [DATA_W-1:0] rsp_solution_value;
   logic                     rsp_singular;
   logic                     rsp_last_result;
   logic                     csr_write_enable;
   logic [3:0]               csr_write_data;

   int           element_q[$];
   solution_type solution_q[$];
   int           error_count = 0;
   int           send_gap_max = 11;
   int           recv_stall_max = 11;
   int           send_gap = 0;
   int           recv_stall = 0;
   int           elements_queued = 0;

   // Predictor state
   int       coef[MAX_EQ][MAX_EQ+1];
   int       root[MAX_EQ];
   int       load_count = 0;
   bit       zero_pivot = 0;
   bit [3:0] equation_reg = 4'd8;

   gaussian_elimination_solver_top #(.MAX_EQUATIONS(MAX_EQ)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_element_value(req_element_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_variable_index(rsp_variable_index),
      .rsp_solution_value(rsp_solution_value),
      .rsp_singular(rsp_singular), .rsp_last_result(rsp_last_result),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int saturate(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic int fix_mul(int a, int b);
      return saturate((longint'(a) * longint'(b)) / 65536);
   endfunction

   function automatic int fix_div(longint num, int den);
      return saturate((num * 65536) / longint'(den));
   endfunction

   function automatic int active_count();
      if (equation_reg == 0) return 1;
      if (equation_reg > MAX_EQ) return MAX_EQ;
      return equation_reg;
   endfunction

   function automatic void solve_system(int n);
      int     piv;
      int     ratio;
      longint acc;
      for (int i = 0; i < n; i++) begin
         piv = coef[i][i];
         if (piv == 0) begin
            zero_pivot = 1;
            continue;
         end
         for (int j = i + 1; j < n; j++) begin
            ratio = fix_div(longint'(coef[j][i]), piv);
            for (int k = 0; k <= n; k++)
               coef[j][k] = saturate(longint'(coef[j][k]) - longint'(fix_mul(ratio, coef[i][k])));
         end
      end
      for (int i = n - 1; i >= 0; i--) begin
         acc = 0;
         piv = coef[i][i];
         for (int j = i + 1; j < n; j++)
            acc += longint'(fix_mul(coef[i][j], root[j]));
         if (piv == 0) begin
            zero_pivot = 1;
            root[i] = 0;
         end else begin
            root[i] = fix_div(longint'(coef[i][n]) - acc, piv);
         end
      end
   endfunction

   // Takes one accepted element and queues the solutions it completes.
   function automatic void accept_element(int value);
      int n;
      int total;
      solution_type s;
      n = active_count();
      total = n * (n + 1);
      if (load_count >= total) load_count = 0;
      if (load_count == 0) zero_pivot = 0;
      coef[load_count / (n + 1)][load_count % (n + 1)] = value;
      load_count++;
      if (load_count < total) return;
      load_count = 0;
      zero_pivot = 0;
      solve_system(n);
      for (int i = 0; i < n; i++) begin
         s.index = i[2:0];
         s.value = zero_pivot ? 0 : root[i];
         s.singular = zero_pivot;
         s.last = (i == n - 1);
         solution_q.push_back(s);
      end
   endfunction

   // Element driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) accept_element(req_element_value);
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (element_q.size() > 0) begin
            req_valid <= 1'b1;
            req_element_value <= element_q.pop_front();
            send_gap <= $urandom_range(0, send_gap_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      solution_type s;
      int           draw;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         if (solution_q.size() == 0) begin
            $display("%0t: unexpected result item index %0d value %h", $time,
                     rsp_variable_index, rsp_solution_value);
            error_count++;
         end else begin
            s = solution_q.pop_front();
            if (rsp_variable_index !== s.index || rsp_solution_value !== s.value ||
                rsp_singular !== s.singular || rsp_last_result !== s.last) begin
               $display("%0t: mismatch expected idx %0d val %h sing %b last %b", $time,
                        s.index, s.value, s.singular, s.last);
               $display("%0t:          actual   idx %0d val %h sing %b last %b", $time,
                        rsp_variable_index, rsp_solution_value, rsp_singular,
                        rsp_last_result);
               error_count++;
            end
         end
         draw = $urandom_range(0, recv_stall_max);
         recv_stall <= draw;
         rsp_stall <= (draw > 0);
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_stall <= (recv_stall > 1);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic wait_idle();
      wait (element_q.size() == 0 && solution_q.size() == 0 && !req_valid);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_count(bit [3:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      equation_reg = value;
      load_count = 0;
      zero_pivot = 0;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic void queue_element(int value);
      element_q.push_back(value);
      elements_queued++;
   endfunction

   // Kinds: well conditioned, raw random words, or a zero leading pivot.
   function automatic void queue_system(int n);
      int kind;
      int v;
      kind = $urandom_range(0, 9);
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c <= n; c++) begin
            if (kind == 7 || kind == 8) begin
               v = $urandom;
            end else if (r == c) begin
               v = $urandom_range(2 << 16, 8 << 16);
               if ($urandom_range(0, 1)) v = -v;
            end else if (c == n) begin
               v = int'($urandom_range(0, 32 << 16)) - (16 << 16);
            end else begin
               v = int'($urandom_range(0, 1 << 17)) - (1 << 16);
            end
            if (kind == 9 && r == 0 && c == 0) v = 0;
            queue_element(v);
         end
      end
   endfunction

   initial begin
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_element_value = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Single unknowns at the extremes, including a zero pivot.
      write_count(4'd1);
      queue_element(32'h00010000); queue_element(32'h7fffffff);
      queue_element(32'h00000001); queue_element(32'h80000000);
      queue_element(32'h80000000); queue_element(32'h7fffffff);
      queue_element(32'hffff0000); queue_element(32'h80000000);
      queue_element(32'h00000000); queue_element(32'h12345678);
      // A zero count behaves as one equation.
      write_count(4'd0);
      queue_element(32'hffffffff); queue_element(32'h00000000);
      // A write in the middle of a load drops the partial system.
      write_count(4'd2);
      queue_element(32'h00030000); queue_element(32'h00010000);
      queue_element(32'h00020000);
      write_count(4'd2);
      queue_system(2);
      // Counts above the maximum behave as the maximum.
      write_count(4'd15);
      queue_system(MAX_EQ);

      // Systems are kept small enough near the end to land close to 250 items.
      while (elements_queued < 245) begin
         n = $urandom_range(1, MAX_EQ);
         if (n > 4 && $urandom_range(0, 3) != 0) n = $urandom_range(1, 4);
         while (n > 1 && elements_queued + n * (n + 1) > 260) n--;
         write_count(n[3:0]);
         send_gap_max = $urandom_range(0, 2) == 0 ? 0 : 11;
         recv_stall_max = $urandom_range(0, 2) == 0 ? 0 : 11;
         repeat ($urandom_range(1, 3)) begin
            if (elements_queued + n * (n + 1) <= 260) queue_system(n);
         end
      end

      wait_idle();
      if (error_count == 0) begin
         $display("** gaussian_elimination_solver_top: PASSED **");
      end else begin
         $display("** gaussian_elimination_solver_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("** gaussian_elimination_solver_top: FAILED **");
      $finish;
   end

endmodule

@@ gaussian_elimination_solver_top.f @@
design/ges_pkg.sv
design/ges_ram.sv
design/ges_datapath.sv
design/ges_ctrl.sv
design/gaussian_elimination_solver_top.sv
bench/tb_top.sv
